@@ src/swsr_pkg.sv @@
// shared types and constants for the single-wire sensor reader
// no dependencies; imported by swsr_fsm and single_wire_sensor_reader
package swsr_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned TICK_W        = 16;
    localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int unsigned FRAME_W       = 4;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic [TICK_W-1:0]  START_LOW_RESET  = TICK_W'(20000);
    localparam logic [TICK_W-1:0]  RESP_DELAY_RESET = TICK_W'(40);
    localparam logic [TICK_W-1:0]  SAMPLE_DLY_RESET = TICK_W'(30);
    localparam logic [FRAME_W-1:0] FRAME_LEN_RESET  = FRAME_W'(5);
    localparam logic [FRAME_W-1:0] FRAME_LEN_MAX    = FRAME_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LOW  = 2'd0,
        CFG_RESP_DELAY = 2'd1,
        CFG_SAMPLE_DLY = 2'd2,
        CFG_FRAME_LEN  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_LOW  = 4'd1,
        PH_START_HIGH = 4'd2,
        PH_RESP_DELAY = 4'd3,
        PH_RESP_LOW1  = 4'd4,
        PH_RESP_HIGH  = 4'd5,
        PH_RESP_LOW2  = 4'd6,
        PH_BIT_HIGH   = 4'd7,
        PH_BIT_DELAY  = 4'd8,
        PH_BIT_LOW    = 4'd9
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0]  start_low_ticks;
        logic [TICK_W-1:0]  response_delay_ticks;
        logic [TICK_W-1:0]  sample_delay_ticks;
        logic [FRAME_W-1:0] bytes_per_frame;
    } cfg_t;

    typedef struct packed {
        logic       line_output_enable;
        logic       line_output_level;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       busy_res;
    } result_t;

endpackage

@@ src/single_wire_sensor_reader.sv @@
// top level of the single-wire sensor reader: config registers, skid stage, result register
// depends on swsr_pkg and swsr_fsm
//
//  channel | signals                                   | beat moves
//  --------+-------------------------------------------+-----------------------------------
//  in      | in_valid, in_stall, start_request,        | one line sample (one tick)
//          | line_level                                |
//  out     | out_valid, out_stall, line_output_enable, | one result per accepted tick
//          | line_output_level, byte_valid, data_byte, |
//          | last_byte, busy_res                       |
//  cfg     | cfg_write, cfg_index, cfg_data            | one register write, no wait
//
// the sequencer updates its state at the accepting edge and the result lands at that same
// edge in the output register, or in the skid if the output stalls, so a new beat can enter
// each cycle that in_stall is low; a one-entry skid register behind the output register
// absorbs a beat accepted while the output stalls; in_stall is the skid-full register
// reset (rst_n low, async) puts the sequencer in idle and loads the config reset values
// results leave in the order their ticks came in, one for each accepted tick
module single_wire_sensor_reader (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_request,
    input  logic                                line_level,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                line_output_enable,
    output logic                                line_output_level,
    output logic                                byte_valid,
    output logic [7:0]                          data_byte,
    output logic                                last_byte,
    output logic                                busy_res,
    // config port
    input  logic                                cfg_write,
    input  logic [swsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import swsr_pkg::*;

    cfg_t    cfg_reg;
    result_t step_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_full_reg;
    logic    in_accept;
    logic    out_free;

    // config registers, a write applies from the next tick on, even mid-transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks      <= START_LOW_RESET;
            cfg_reg.response_delay_ticks <= RESP_DELAY_RESET;
            cfg_reg.sample_delay_ticks   <= SAMPLE_DLY_RESET;
            cfg_reg.bytes_per_frame      <= FRAME_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_LOW:  cfg_reg.start_low_ticks      <= cfg_data[TICK_W-1:0];
                CFG_RESP_DELAY: cfg_reg.response_delay_ticks <= cfg_data[TICK_W-1:0];
                CFG_SAMPLE_DLY: cfg_reg.sample_delay_ticks   <= cfg_data[TICK_W-1:0];
                CFG_FRAME_LEN:  cfg_reg.bytes_per_frame      <= cfg_data[FRAME_W-1:0];
                default:        cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    // beat accepted when the skid has room
    assign in_stall  = skid_full_reg;
    assign in_accept = in_valid && !skid_full_reg;
    // output register can take a new beat this cycle
    assign out_free  = !out_valid_reg || !out_stall;

    swsr_fsm u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (in_accept),
        .start_request (start_request),
        .line_level    (line_level),
        .cfg           (cfg_reg),
        .result        (step_result)
    );

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid drains first; while it is full no beat is accepted
            out_valid_reg <= skid_full_reg || in_accept;
            skid_full_reg <= 1'b0;
        end
        else if (in_accept)
            skid_full_reg <= 1'b1;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_full_reg)
                out_reg <= skid_reg;
            else if (in_accept)
                out_reg <= step_result;
        end
        else if (in_accept)
            skid_reg <= step_result;
    end

    assign out_valid          = out_valid_reg;
    assign line_output_enable = out_reg.line_output_enable;
    assign line_output_level  = out_reg.line_output_level;
    assign byte_valid         = out_reg.byte_valid;
    assign data_byte          = out_reg.data_byte;
    assign last_byte          = out_reg.last_byte;
    assign busy_res           = out_reg.busy_res;

endmodule

@@ src/swsr_fsm.sv @@
// transaction sequencer: phase, tick counter, bit and byte counters
// depends on swsr_pkg
module swsr_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              start_request,
    input  logic              line_level,
    input  swsr_pkg::cfg_t    cfg,
    output swsr_pkg::result_t result
);
    import swsr_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [7:0]             shift_reg, shift_next;
    logic [BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic [BIT_IDX_W-1:0]   byte_idx_reg, byte_idx_next;
    logic [FRAME_W-1:0]     frame_len;
    logic [TICK_W-1:0]      tick_inc;
    logic                   byte_done;
    logic                   frame_done;

    // 0 acts as 1, anything above 8 acts as 8
    always_comb
    begin
        if (cfg.bytes_per_frame == '0)
            frame_len = FRAME_W'(1);
        else if (cfg.bytes_per_frame > FRAME_LEN_MAX)
            frame_len = FRAME_LEN_MAX;
        else
            frame_len = cfg.bytes_per_frame;
    end

    assign tick_inc   = tick_reg + TICK_W'(1);
    assign byte_done  = (bit_idx_reg == BIT_IDX_W'(BITS_PER_BYTE - 1));
    assign frame_done = (FRAME_W'(byte_idx_reg) + FRAME_W'(1)) >= frame_len;

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        shift_next    = shift_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_request)
                begin
                    phase_next    = PH_START_LOW;
                    tick_next     = '0;
                    shift_next    = '0;
                    bit_idx_next  = '0;
                    byte_idx_next = '0;
                end
            end
            PH_START_LOW:
            begin
                if ((tick_inc == '0) || (tick_inc >= cfg.start_low_ticks))
                begin
                    phase_next = PH_START_HIGH;
                    tick_next  = '0;
                end
                else
                    tick_next = tick_inc;
            end
            PH_START_HIGH:
            begin
                phase_next = PH_RESP_DELAY;
                tick_next  = '0;
            end
            PH_RESP_DELAY:
            begin
                if (tick_reg >= cfg.response_delay_ticks)
                begin
                    phase_next = line_level ? PH_RESP_LOW1 : PH_RESP_HIGH;
                    tick_next  = '0;
                end
                else
                    tick_next = tick_inc;
            end
            PH_RESP_LOW1:
            begin
                if (!line_level)
                    phase_next = PH_RESP_HIGH;
            end
            PH_RESP_HIGH:
            begin
                if (line_level)
                    phase_next = PH_RESP_LOW2;
            end
            PH_RESP_LOW2:
            begin
                if (!line_level)
                    phase_next = PH_BIT_HIGH;
            end
            PH_BIT_HIGH:
            begin
                if (line_level)
                begin
                    phase_next = PH_BIT_DELAY;
                    tick_next  = '0;
                end
            end
            PH_BIT_DELAY:
            begin
                if (tick_reg >= cfg.sample_delay_ticks)
                begin
                    shift_next = {shift_reg[6:0], line_level};
                    phase_next = PH_BIT_LOW;
                    tick_next  = '0;
                end
                else
                    tick_next = tick_inc;
            end
            PH_BIT_LOW:
            begin
                if (!line_level)
                begin
                    if (byte_done)
                    begin
                        bit_idx_next = '0;
                        shift_next   = '0;
                        if (frame_done)
                        begin
                            byte_idx_next = '0;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            byte_idx_next = byte_idx_reg + BIT_IDX_W'(1);
                            phase_next    = PH_BIT_HIGH;
                        end
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                        phase_next   = PH_BIT_HIGH;
                    end
                end
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // outputs reflect the phase held at the start of the beat
    always_comb
    begin
        result                    = '0;
        result.busy_res           = (phase_reg != PH_IDLE);
        result.line_output_enable = (phase_reg == PH_START_LOW) ||
                                    (phase_reg == PH_START_HIGH);
        result.line_output_level  = (phase_reg == PH_START_HIGH);
        if ((phase_reg == PH_BIT_LOW) && !line_level && byte_done)
        begin
            result.byte_valid = 1'b1;
            result.data_byte  = shift_reg;
            result.last_byte  = frame_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            shift_reg    <= '0;
            bit_idx_reg  <= '0;
            byte_idx_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            shift_reg    <= shift_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
        end
    end

endmodule
